// ===== rtl/ipcs_pkg.sv =====
// Package: shared constants, types and the IUPAC symbol decoder for the profile scorer.
`timescale 1ns / 1ps
`default_nettype none
package ipcs_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int COUNT_BITS  = 24;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int LEN_W       = 13;
	localparam int TOTAL_W     = COUNT_BITS + 3;
	localparam int DEV_W       = 19;
	localparam int CONF_W      = 29;
	localparam int WGT_W       = 7;
	localparam int ROW_W       = 6 * COUNT_BITS;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_SCORE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [14:0] DEV_OUT_MAX  = 15'd25600;
	localparam logic [16:0] CONF_OUT_MAX = 17'd65536;

	typedef logic [5:0][WGT_W-1:0] weights_t;
	typedef logic [5:0][COUNT_BITS-1:0] row_t;

	typedef struct packed {
		logic     legal;
		weights_t w;
	} decode_t;

	function automatic decode_t decode_sym(input logic [7:0] sym_in);
		decode_t    d;
		logic [7:0] s;
		d = '0;
		d.legal = 1'b1;
		s = (sym_in >= 8'h61 && sym_in <= 8'h7a) ? sym_in - 8'd32 : sym_in;
		case (s)
			"A": d.w[0] = 7'd100;
			"T", "U": d.w[1] = 7'd100;
			"C": d.w[2] = 7'd100;
			"G": d.w[3] = 7'd100;
			"R": begin d.w[0] = 7'd50; d.w[3] = 7'd50; end
			"Y": begin d.w[1] = 7'd50; d.w[2] = 7'd50; end
			"M": begin d.w[0] = 7'd50; d.w[2] = 7'd50; end
			"K": begin d.w[1] = 7'd50; d.w[3] = 7'd50; end
			"W": begin d.w[0] = 7'd50; d.w[1] = 7'd50; end
			"S": begin d.w[2] = 7'd50; d.w[3] = 7'd50; end
			"B": begin d.w[1] = 7'd33; d.w[2] = 7'd33; d.w[3] = 7'd33; end
			"D": begin d.w[0] = 7'd33; d.w[1] = 7'd33; d.w[3] = 7'd33; end
			"H": begin d.w[0] = 7'd33; d.w[1] = 7'd33; d.w[2] = 7'd33; end
			"V": begin d.w[0] = 7'd33; d.w[2] = 7'd33; d.w[3] = 7'd33; end
			"N", "X": d.w = {7'd0, 7'd0, 7'd25, 7'd25, 7'd25, 7'd25};
			".": d.w[4] = 7'd1;
			"-": d.w[5] = 7'd1;
			default: d.legal = 1'b0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/iupac_profile_consensus_scorer_core.sv =====
// Top level: IUPAC profile consensus scorer with profile RAM and shared iterative divider.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  command   | start / busy            | operation, symbol, column
//  result    | result_valid (1 cycle)  | pass_kind, illegal_seen, deviation_x256,
//            |                         | conformity_q16
//  config    | APB psel/penable/pready | paddr, pwdata, prdata (columns_in_use)
//
// Add and clear pass through load and finish; score also scans the six counts and runs
// a division for each count above its weight (up to 4). An add or clear pass end adds nothing;
// a score pass end adds two 29-step divisions.
// The divider, one quotient bit a cycle, sets the score rate.
// After reset the profile RAM is swept to zero, all 4096 columns, with busy high.
// Results cannot be stalled; busy falls in the same cycle that result_valid is raised.
`timescale 1ns / 1ps
`default_nettype none
module iupac_profile_consensus_scorer_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire [1:0]                operation,
	input  wire [7:0]                symbol,
	input  wire [11:0]               column,
	output logic                     result_valid,
	output logic [1:0]               pass_kind,
	output logic                     illegal_seen,
	output logic [14:0]              deviation_x256,
	output logic [16:0]              conformity_q16,
	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire [1:0]                paddr,
	input  wire [31:0]               pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import ipcs_pkg::*;

	localparam logic [2:0] S_SWEEP = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_SC    = 3'd3;
	localparam logic [2:0] S_DIVC  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_DIVD  = 3'd6;
	localparam logic [2:0] S_DIVF  = 3'd7;

	logic [2:0]         state_q;
	logic [COL_W-1:0]   sweep_q;
	logic [LEN_W-1:0]   len_q;
	logic [1:0]         op_q;
	logic [COL_W-1:0]   col_q;
	weights_t           w_q;
	row_t               row_q;
	logic [TOTAL_W-1:0] total_q;
	logic [2:0]         j_q;
	logic [DEV_W-1:0]   dev_sum_q;
	logic [CONF_W-1:0]  conf_sum_q;
	logic               ill_q;
	logic [14:0]        dev_res_q;

	logic [TOTAL_W-1:0] div_r_q;
	logic [28:0]        div_n_q;
	logic [28:0]        div_quo_q;
	logic [TOTAL_W-1:0] div_d_q;
	logic [4:0]         div_cnt_q;

	logic               ram_we;
	logic [COL_W-1:0]   ram_addr;
	logic [ROW_W-1:0]   ram_wdata;
	logic [ROW_W-1:0]   ram_rdata;
	row_t               rd_row;
	row_t               add_row;
	logic [TOTAL_W-1:0] rd_total;

	decode_t            dec;
	logic               accept;
	logic [LEN_W-1:0]   eff_len;
	logic [COL_W-1:0]   last_col;

	logic [TOTAL_W:0]   div_rr;
	logic               div_ge;
	logic [TOTAL_W-1:0] div_r_nx;
	logic [28:0]        div_quo_nx;
	logic               div_last;

	logic [WGT_W-1:0]      cur_w;
	logic [COUNT_BITS-1:0] cur_c;
	logic [COUNT_BITS-1:0] cur_x;
	logic [DEV_W:0]        dev_add;
	logic [CONF_W:0]       conf_add;

	assign dec      = decode_sym(symbol);
	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign pready   = 1'b1;
	assign prdata   = (paddr == 2'd0) ? {{(32-LEN_W){1'b0}}, len_q} : '0;
	assign eff_len  = (len_q == '0) ? LEN_W'(1) :
	                  (len_q > LEN_W'(MAX_COLUMNS)) ? LEN_W'(MAX_COLUMNS) : len_q;
	assign last_col = COL_W'(eff_len - LEN_W'(1));

	assign rd_row = row_t'(ram_rdata);

	always_comb begin
		rd_total = '0;
		for (int k = 0; k < 6; k++) begin
			rd_total = rd_total + TOTAL_W'(rd_row[k]);
			if ({1'b0, rd_row[k]} + (COUNT_BITS+1)'(w_q[k]) > {1'b0, {COUNT_BITS{1'b1}}}) begin
				add_row[k] = {COUNT_BITS{1'b1}};
			end else begin
				add_row[k] = rd_row[k] + COUNT_BITS'(w_q[k]);
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = col_q;
		case (state_q)
			S_SWEEP: begin
				ram_we   = 1'b1;
				ram_addr = sweep_q;
			end
			S_IDLE: ram_addr = column;
			S_LOAD: begin
				if (op_q == OP_ADD) begin
					ram_we    = 1'b1;
					ram_wdata = ROW_W'(add_row);
				end else if (op_q == OP_CLEAR) begin
					ram_we = 1'b1;
				end
			end
			default: ram_addr = col_q;
		endcase
	end

	ipcs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_COLUMNS)) u_profile (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign div_rr     = {div_r_q, div_n_q[28]};
	assign div_ge     = div_rr >= {1'b0, div_d_q};
	assign div_r_nx   = div_ge ? TOTAL_W'(div_rr - {1'b0, div_d_q}) : TOTAL_W'(div_rr);
	assign div_quo_nx = {div_quo_q[27:0], div_ge};
	assign div_last   = (div_cnt_q == 5'd1);

	assign cur_w    = w_q[j_q];
	assign cur_c    = row_q[j_q];
	assign cur_x    = cur_c - COUNT_BITS'(cur_w);
	assign dev_add  = {1'b0, dev_sum_q} + (DEV_W+1)'(cur_w);
	assign conf_add = {1'b0, conf_sum_q} + (CONF_W+1)'(div_quo_nx[16:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			len_q        <= LEN_W'(MAX_COLUMNS);
			dev_sum_q    <= '0;
			conf_sum_q   <= '0;
			ill_q        <= 1'b0;
			result_valid <= 1'b0;
			j_q          <= '0;
			div_cnt_q    <= '0;
		end else begin
			result_valid <= 1'b0;
			if (psel && penable && pwrite) begin
				len_q <= pwdata[LEN_W-1:0];
			end
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + COL_W'(1);
					if (sweep_q == COL_W'(MAX_COLUMNS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && operation != OP_NONE) begin
						state_q <= S_LOAD;
						if (operation != OP_CLEAR && !dec.legal) begin
							ill_q <= 1'b1;
						end
					end
				end
				S_LOAD: begin
					j_q     <= '0;
					state_q <= (op_q == OP_SCORE) ? S_SC : S_FIN;
				end
				S_SC: begin
					if (cur_w != '0 && cur_c <= COUNT_BITS'(cur_w)) begin
						dev_sum_q <= dev_add[DEV_W] ? {DEV_W{1'b1}} : dev_add[DEV_W-1:0];
					end
					if (cur_w != '0 && cur_c > COUNT_BITS'(cur_w) && total_q != '0) begin
						div_cnt_q <= 5'd17;
						state_q   <= S_DIVC;
					end else if (j_q == 3'd5) begin
						state_q <= S_FIN;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				S_DIVC: begin
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_last) begin
						conf_sum_q <= conf_add[CONF_W] ? {CONF_W{1'b1}} : conf_add[CONF_W-1:0];
						if (j_q == 3'd5) begin
							state_q <= S_FIN;
						end else begin
							j_q     <= j_q + 3'd1;
							state_q <= S_SC;
						end
					end
				end
				S_FIN: begin
					if (col_q != last_col) begin
						state_q <= S_IDLE;
					end else if (op_q == OP_SCORE) begin
						div_cnt_q <= 5'd29;
						state_q   <= S_DIVD;
					end else begin
						result_valid <= 1'b1;
						dev_sum_q    <= '0;
						conf_sum_q   <= '0;
						ill_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_DIVD: begin
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_last) begin
						div_cnt_q <= 5'd29;
						state_q   <= S_DIVF;
					end
				end
				S_DIVF: begin
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_last) begin
						result_valid <= 1'b1;
						dev_sum_q    <= '0;
						conf_sum_q   <= '0;
						ill_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= operation;
					col_q <= column;
					w_q   <= (operation == OP_CLEAR) ? '0 : dec.w;
				end
			end
			S_LOAD: begin
				row_q   <= rd_row;
				total_q <= rd_total;
			end
			S_SC: begin
				div_r_q   <= TOTAL_W'(cur_x[COUNT_BITS-1:1]);
				div_n_q   <= {cur_x[0], 28'd0};
				div_quo_q <= '0;
				div_d_q   <= total_q;
			end
			S_DIVC, S_DIVF: begin
				div_r_q   <= div_r_nx;
				div_n_q   <= {div_n_q[27:0], 1'b0};
				div_quo_q <= div_quo_nx;
			end
			S_FIN: begin
				div_r_q   <= '0;
				div_n_q   <= {2'b00, dev_sum_q, 8'd0};
				div_quo_q <= '0;
				div_d_q   <= TOTAL_W'(eff_len);
				pass_kind      <= op_q;
				illegal_seen   <= ill_q;
				deviation_x256 <= '0;
				conformity_q16 <= '0;
			end
			S_DIVD: begin
				div_r_q   <= div_r_nx;
				div_n_q   <= {div_n_q[27:0], 1'b0};
				div_quo_q <= div_quo_nx;
				if (div_last) begin
					dev_res_q <= (div_quo_nx > 29'(DEV_OUT_MAX)) ? DEV_OUT_MAX
					             : div_quo_nx[14:0];
					div_r_q   <= '0;
					div_n_q   <= conf_sum_q;
					div_quo_q <= '0;
				end
			end
			default: ;
		endcase
		if (state_q == S_DIVF && div_last) begin
			deviation_x256 <= dev_res_q;
			conformity_q16 <= (div_quo_nx > 29'(CONF_OUT_MAX)) ? CONF_OUT_MAX
			                  : div_quo_nx[16:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ipcs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ipcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/ipcs_checker.sv =====
// Port-level checker for the profile scorer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ipcs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire [1:0]  operation,
	input wire        result_valid,
	input wire [1:0]  pass_kind,
	input wire [14:0] deviation_x256,
	input wire [16:0] conformity_q16
);
	import ipcs_pkg::*;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pass_kind != OP_NONE)
		else $error("result with unused pass kind");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pass_kind != OP_SCORE |-> deviation_x256 == '0 && conformity_q16 == '0)
		else $error("non-score result carries scores");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> deviation_x256 <= DEV_OUT_MAX && conformity_q16 <= CONF_OUT_MAX)
		else $error("score out of range");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation != OP_NONE |=> busy)
		else $error("transaction taken without going busy");

	a_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy && $past(busy))
		else $error("result outside a transaction");
endmodule

bind iupac_profile_consensus_scorer_core ipcs_checker u_ipcs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.operation      (operation),
	.result_valid   (result_valid),
	.pass_kind      (pass_kind),
	.deviation_x256 (deviation_x256),
	.conformity_q16 (conformity_q16)
);
`default_nettype wire
